// ===== src/dtm_pkg.sv =====
// ----------------------------------------------------------------------------
// dtm_pkg
// Shared types and constants for the dirty tile map tracker: item layouts,
// register indexes, function codes and the command passed front to back.
// ----------------------------------------------------------------------------
package dtm_pkg;

  localparam int PIX_W         = 12;
  localparam int SUM_W         = 13;
  localparam int TILE_IDX_W    = 3;
  localparam int ORIGIN_W      = 15;
  localparam int CFG_IDX_W     = 2;
  localparam int DEF_GRID_COLS = 8;
  localparam int DEF_GRID_ROWS = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT   = 2'd3;

  // Reset values of the configuration registers
  localparam logic [PIX_W-1:0] RST_SCREEN_WIDTH  = 12'd640;
  localparam logic [PIX_W-1:0] RST_SCREEN_HEIGHT = 12'd480;
  localparam logic [PIX_W-1:0] RST_TILE_WIDTH    = 12'd80;
  localparam logic [PIX_W-1:0] RST_TILE_HEIGHT   = 12'd60;

  // Function codes
  localparam logic FUNC_MARK = 1'b0;
  localparam logic FUNC_SCAN = 1'b1;

  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] rect_left;
    logic [PIX_W-1:0] rect_top;
    logic [PIX_W-1:0] rect_width;
    logic [PIX_W-1:0] rect_height;
  } req_t;

  typedef struct packed {
    logic [TILE_IDX_W-1:0] tile_col;
    logic [TILE_IDX_W-1:0] tile_row;
    logic [ORIGIN_W-1:0]   origin_x;
    logic [ORIGIN_W-1:0]   origin_y;
    logic                  map_empty;
    logic                  last;
  } rsp_t;

  typedef struct packed {
    logic [PIX_W-1:0] screen_width;
    logic [PIX_W-1:0] screen_height;
    logic [PIX_W-1:0] tile_width;
    logic [PIX_W-1:0] tile_height;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic                  scan;
    logic                  none;
    logic [TILE_IDX_W-1:0] c0;
    logic [TILE_IDX_W-1:0] c1;
    logic [TILE_IDX_W-1:0] r0;
    logic [TILE_IDX_W-1:0] r1;
  } cmd_t;

  // Queue write side driven by the front
  typedef struct packed {
    logic push;
  } qwr_t;

endpackage

// ===== src/dtm_front.sv =====
// ----------------------------------------------------------------------------
// dtm_front
// Accepts items, clamps the rectangle origin and turns a mark's pixel edges
// into tile indices with four subtract-and-compare dividers, one step a cycle.
// ----------------------------------------------------------------------------
module dtm_front #(
  parameter int GRID_COLS = dtm_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS = dtm_pkg::DEF_GRID_ROWS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  dtm_pkg::req_t req,
  input  dtm_pkg::cfg_t cfg,
  output dtm_pkg::cmd_t cmd,
  output logic          q_push,
  input  logic          q_full
);
  import dtm_pkg::*;

  localparam logic [TILE_IDX_W-1:0] COL_LIM = TILE_IDX_W'(GRID_COLS - 1);
  localparam logic [TILE_IDX_W-1:0] ROW_LIM = TILE_IDX_W'(GRID_ROWS - 1);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]            state;
  logic                  scan;
  logic                  none;
  logic [SUM_W-1:0]      rem [4];
  logic [TILE_IDX_W-1:0] quo [4];

  logic [SUM_W-1:0]      size_x;
  logic [SUM_W-1:0]      size_y;
  logic [SUM_W-1:0]      size [4];
  logic [TILE_IDX_W-1:0] lim [4];
  logic [3:0]            step;
  logic [PIX_W-1:0]      xc;
  logic [PIX_W-1:0]      yc;
  logic                  accept;

  // Treat a zero tile size as one pixel
  assign size_x = (cfg.tile_width == '0) ? SUM_W'(1) : SUM_W'(cfg.tile_width);
  assign size_y = (cfg.tile_height == '0) ? SUM_W'(1) : SUM_W'(cfg.tile_height);

  // Clamp the rectangle origin to the screen
  assign xc = (req.rect_left > cfg.screen_width) ? cfg.screen_width : req.rect_left;
  assign yc = (req.rect_top > cfg.screen_height) ? cfg.screen_height : req.rect_top;

  assign req_stall = (state != F_IDLE);
  assign accept    = req_valid && !req_stall;

  // Divider step: subtract while the quotient is below its saturation limit
  always_comb begin
    size[0] = size_x;
    size[1] = size_x;
    size[2] = size_y;
    size[3] = size_y;
    lim[0]  = COL_LIM;
    lim[1]  = COL_LIM;
    lim[2]  = ROW_LIM;
    lim[3]  = ROW_LIM;
    for (int k = 0; k < 4; k++) begin
      step[k] = (quo[k] != lim[k]) && (rem[k] >= size[k]);
    end
  end

  // Hand the finished command to the queue
  assign q_push  = (state == F_PUSH) && !q_full;
  assign cmd.scan = scan;
  assign cmd.none = none;
  assign cmd.c0   = quo[0];
  assign cmd.c1   = quo[1];
  assign cmd.r0   = quo[2];
  assign cmd.r1   = quo[3];

  // Sequence: take item, divide (marks only), push
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            state <= (req.func == FUNC_SCAN) ? F_PUSH : F_DIV;
          end
        end
        F_DIV: begin
          if (step == '0) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  // Load operands on accept, iterate the dividers while in DIV
  always_ff @(posedge clk) begin
    if (accept) begin
      scan   <= req.func;
      none   <= (req.rect_width == '0) || (req.rect_height == '0);
      rem[0] <= SUM_W'(xc);
      rem[1] <= SUM_W'(xc) + SUM_W'(req.rect_width) - SUM_W'(1);
      rem[2] <= SUM_W'(yc);
      rem[3] <= SUM_W'(yc) + SUM_W'(req.rect_height) - SUM_W'(1);
      for (int k = 0; k < 4; k++) begin
        quo[k] <= '0;
      end
    end else if (state == F_DIV) begin
      for (int k = 0; k < 4; k++) begin
        if (step[k]) begin
          rem[k] <= rem[k] - size[k];
          quo[k] <= quo[k] + TILE_IDX_W'(1);
        end
      end
    end
  end

endmodule

// ===== src/dtm_queue.sv =====
// ----------------------------------------------------------------------------
// dtm_queue
// Two-entry command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module dtm_queue (
  input  logic          clk,
  input  logic          rst,
  input  dtm_pkg::qwr_t wr,
  input  dtm_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          pop,
  output logic          rd_valid,
  output dtm_pkg::cmd_t rd_cmd
);
  import dtm_pkg::*;

  cmd_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_cmd   = mem[rptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wptr] <= wr_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr.push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({wr.push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/dtm_back.sv =====
// ----------------------------------------------------------------------------
// dtm_back
// Holds the dirty map, applies marks, on a scan walks and clears it one tile
// a cycle, pausing at a dirty tile on a stall; drives the result register.
// ----------------------------------------------------------------------------
module dtm_back #(
  parameter int GRID_COLS = dtm_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS = dtm_pkg::DEF_GRID_ROWS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  input  dtm_pkg::cmd_t             cmd,
  output logic                      cmd_pop,
  input  logic [dtm_pkg::PIX_W-1:0] tile_width,
  input  logic [dtm_pkg::PIX_W-1:0] tile_height,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output dtm_pkg::rsp_t             rsp
);
  import dtm_pkg::*;

  localparam int COL_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ROW_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_SCAN = 1'b1;

  logic                               state;
  logic [COL_W-1:0]                   col;
  logic [ROW_W-1:0]                   row;
  logic [GRID_COLS-1:0][GRID_ROWS-1:0] dirty;

  logic                               state_next;
  logic [COL_W-1:0]                   col_next;
  logic [ROW_W-1:0]                   row_next;
  logic [GRID_COLS-1:0][GRID_ROWS-1:0] dirty_next;
  logic [GRID_COLS-1:0][GRID_ROWS-1:0] dirty_clr;
  logic [GRID_COLS-1:0][GRID_ROWS-1:0] mark_mask;
  logic                               out_free;
  logic                               rest;
  logic                               emit;
  logic [TILE_IDX_W-1:0]              col_e;
  logic [TILE_IDX_W-1:0]              row_e;
  logic                               empty_e;
  logic                               last_e;

  assign out_free = !rsp_valid || !rsp_stall;

  // Rectangle of tiles covered by a mark
  always_comb begin
    for (int c = 0; c < GRID_COLS; c++) begin
      for (int r = 0; r < GRID_ROWS; r++) begin
        mark_mask[c][r] = (TILE_IDX_W'(c) >= cmd.c0) && (TILE_IDX_W'(c) <= cmd.c1) &&
                          (TILE_IDX_W'(r) >= cmd.r0) && (TILE_IDX_W'(r) <= cmd.r1);
      end
    end
  end

  // Map with the current tile dropped, and whether anything remains after it
  always_comb begin
    dirty_clr           = dirty;
    dirty_clr[col][row] = 1'b0;
  end
  assign rest = |dirty_clr;

  // Execute commands and walk the map
  always_comb begin
    state_next = state;
    col_next   = col;
    row_next   = row;
    dirty_next = dirty;
    cmd_pop    = 1'b0;
    emit       = 1'b0;
    col_e      = '0;
    row_e      = '0;
    empty_e    = 1'b1;
    last_e     = 1'b1;
    case (state)
      B_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if (!cmd.scan) begin
            if (!cmd.none) begin
              dirty_next = dirty | mark_mask;
            end
            emit = 1'b1;
          end else if (dirty == '0) begin
            emit = 1'b1;
          end else begin
            state_next = B_SCAN;
            col_next   = '0;
            row_next   = '0;
          end
        end
      end
      B_SCAN: begin
        if (!dirty[col][row] || out_free) begin
          if (dirty[col][row]) begin
            emit       = 1'b1;
            col_e      = TILE_IDX_W'(col);
            row_e      = TILE_IDX_W'(row);
            empty_e    = 1'b0;
            last_e     = !rest;
            dirty_next = dirty_clr;
            if (!rest) begin
              state_next = B_IDLE;
            end
          end
          if (row == ROW_LAST) begin
            row_next = '0;
            col_next = col + COL_W'(1);
          end else begin
            row_next = row + ROW_W'(1);
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Control state and map
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      col   <= '0;
      row   <= '0;
      dirty <= '0;
    end else begin
      state <= state_next;
      col   <= col_next;
      row   <= row_next;
      dirty <= dirty_next;
    end
  end

  // Result register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.tile_col  <= col_e;
      rsp.tile_row  <= row_e;
      rsp.origin_x  <= {3'b000, tile_width} * {12'd0, col_e};
      rsp.origin_y  <= {3'b000, tile_height} * {12'd0, row_e};
      rsp.map_empty <= empty_e;
      rsp.last      <= last_e;
    end
  end

endmodule

// ===== src/dirty_tile_map_tracker_core.sv =====
// ----------------------------------------------------------------------------
// dirty_tile_map_tracker_core
// Dirty tile map tracker: marks rectangles into a grid of dirty bits and
// reports the dirty tiles in column-major order on a scan, then clears.
// ----------------------------------------------------------------------------
// Mark: front clamps the origin, runs the divider loop of one subtract per
//   cycle and pushes; back applies it to the map and emits one result.
// Scan: back walks the map one tile per cycle unless a dirty tile meets a stall,
//   stopping after the last dirty tile; a result per dirty tile, or one if clean.
// A new item is taken while the back still works or a result waits (2-deep queue).
// Reset (rst, synchronous): map cleared, registers 640 x 480, tile 80 x 60.
module dirty_tile_map_tracker_core #(
  parameter int GRID_COLS = dtm_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS = dtm_pkg::DEF_GRID_ROWS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  dtm_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output dtm_pkg::rsp_t                 rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dtm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dtm_pkg::PIX_W-1:0]     cfg_data
);
  import dtm_pkg::*;

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t back_cmd;
  qwr_t qwr;
  logic q_full;
  logic q_valid;
  logic q_pop;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= RST_SCREEN_WIDTH;
      cfg.screen_height <= RST_SCREEN_HEIGHT;
      cfg.tile_width    <= RST_TILE_WIDTH;
      cfg.tile_height   <= RST_TILE_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data;
        REG_TILE_WIDTH:    cfg.tile_width    <= cfg_data;
        REG_TILE_HEIGHT:   cfg.tile_height   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dtm_front #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cfg       (cfg),
    .cmd       (front_cmd),
    .q_push    (qwr.push),
    .q_full    (q_full)
  );

  dtm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (qwr),
    .wr_cmd   (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (back_cmd)
  );

  dtm_back #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd         (back_cmd),
    .cmd_pop     (q_pop),
    .tile_width  (cfg.tile_width),
    .tile_height (cfg.tile_height),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp)
  );

endmodule

// ===== src/dtm_checker.sv =====
// ----------------------------------------------------------------------------
// dtm_checker
// Port-level checks on the dirty tile map tracker, bound to the top level.
// ----------------------------------------------------------------------------
module dtm_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input dtm_pkg::rsp_t rsp
);
  import dtm_pkg::*;

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // An empty or mark result always closes its item
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.map_empty |-> rsp.last)
    else $error("empty result without last");

  // An empty or mark result carries no tile position
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.map_empty |->
      rsp.tile_col == '0 && rsp.tile_row == '0 &&
      rsp.origin_x == '0 && rsp.origin_y == '0)
    else $error("empty result with nonzero position");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind dirty_tile_map_tracker_core dtm_checker u_dtm_checker (.*);
